// ----- design/lzbsd_pkg.sv -----
// Shared types, constants and codes of the LZ byte stream decompressor.
`timescale 1ns / 1ps

package lzbsd_pkg;

    // History window; a power of two so that ring addresses wrap by truncation.
    localparam int WINDOW_BYTES = 65536;
    localparam int HIST_AW      = $clog2(WINDOW_BYTES);
    localparam int FILL_W       = HIST_AW + 1;
    localparam int RUN_W        = 15;
    localparam int OFFSET_W     = 23;

    // Command queue between the parser and the executor.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Token and header constants of the compressed format.
    localparam logic [7:0] TOKEN_MATCH_BIT = 8'h80;
    localparam logic [7:0] TOKEN_LONG_BIT  = 8'h40;
    localparam logic [7:0] LEN_MASK        = 8'h3f;
    localparam logic [7:0] OFF_MASK        = 8'h7f;
    localparam int         MIN_MATCH       = 4;

    typedef enum logic [2:0] {
        PH_TOKEN      = 3'd0,
        PH_LIT        = 3'd1,
        PH_LENLO      = 3'd2,
        PH_OFF1       = 3'd3,
        PH_OFF2_SHORT = 3'd4,
        PH_OFF2_LONG  = 3'd5,
        PH_OFF3       = 3'd6,
        PH_COPY       = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA       = 2'd0,
        ST_BAD_OFFSET = 2'd1,
        ST_FEED_BUSY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_LIT    = 2'd0,
        CMD_COPY   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    typedef enum logic {
        ACT_FEED = 1'b0,
        ACT_PULL = 1'b1
    } action_t;

    // One unit of work for the executor.
    typedef struct packed {
        cmd_kind_t            kind;
        logic [7:0]           data;
        status_t              status;
        logic                 last;
        logic [HIST_AW-1:0]   wr_addr;
        logic [HIST_AW-1:0]   rd_addr;
    } cmd_t;

endpackage

// ----- design/lzbsd_front.sv -----
// Stream parser: accepts beats, tracks the header state and issues commands.
`timescale 1ns / 1ps

module lzbsd_front import lzbsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    phase_t                phase_reg, phase_next;
    logic [RUN_W-1:0]      run_left_reg, run_left_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [HIST_AW-1:0]    wr_pos_reg, wr_pos_next;
    logic [FILL_W-1:0]     filled_reg, filled_next;

    logic                  accept;
    logic [OFFSET_W-1:0]   off_short;
    logic [OFFSET_W-1:0]   off_long;
    logic [OFFSET_W-1:0]   off_final;
    logic                  off_bad;
    logic [RUN_W-1:0]      run_dec;
    logic                  finish;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign off_short = {8'd0, offset_reg[6:0], s_tdata};
    assign off_long  = {offset_reg[14:0], s_tdata};
    assign run_dec   = (run_left_reg != '0) ? run_left_reg - RUN_W'(1) : run_left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TOKEN;
            run_left_reg <= '0;
            offset_reg   <= '0;
            wr_pos_reg   <= '0;
            filled_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            run_left_reg <= run_left_next;
            offset_reg   <= offset_next;
            wr_pos_reg   <= wr_pos_next;
            filled_reg   <= filled_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        run_left_next = run_left_reg;
        offset_next   = offset_reg;
        wr_pos_next   = wr_pos_reg;
        filled_next   = filled_reg;
        q_push        = 1'b0;
        q_cmd.kind    = CMD_STATUS;
        q_cmd.data    = s_tdata;
        q_cmd.status  = ST_DATA;
        q_cmd.last    = 1'b0;
        q_cmd.wr_addr = wr_pos_reg;
        q_cmd.rd_addr = wr_pos_reg - offset_reg[HIST_AW-1:0];
        finish        = 1'b0;
        off_final     = off_short;

        if (accept) begin
            if (s_tuser == ACT_PULL) begin
                if (phase_reg == PH_COPY) begin
                    q_push        = 1'b1;
                    q_cmd.kind    = CMD_COPY;
                    q_cmd.last    = (run_dec == '0);
                    run_left_next = run_dec;
                    if (run_dec == '0) begin
                        phase_next = PH_TOKEN;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_TOKEN: begin
                        if ((s_tdata & TOKEN_MATCH_BIT) == 8'd0) begin
                            run_left_next = {7'd0, s_tdata} + RUN_W'(1);
                            phase_next    = PH_LIT;
                        end else if ((s_tdata & TOKEN_LONG_BIT) != 8'd0) begin
                            run_left_next = {7'd0, s_tdata & LEN_MASK};
                            phase_next    = PH_LENLO;
                        end else begin
                            run_left_next = {7'd0, s_tdata & LEN_MASK} + RUN_W'(MIN_MATCH);
                            phase_next    = PH_OFF1;
                        end
                    end
                    PH_LIT: begin
                        q_push        = 1'b1;
                        q_cmd.kind    = CMD_LIT;
                        q_cmd.last    = (run_dec == '0);
                        run_left_next = run_dec;
                        if (run_dec == '0) begin
                            phase_next = PH_TOKEN;
                        end
                    end
                    PH_LENLO: begin
                        run_left_next = {1'b0, run_left_reg[5:0], s_tdata} + RUN_W'(MIN_MATCH);
                        phase_next    = PH_OFF1;
                    end
                    PH_OFF1: begin
                        offset_next = {15'd0, s_tdata & OFF_MASK};
                        phase_next  = s_tdata[7] ? PH_OFF2_LONG : PH_OFF2_SHORT;
                    end
                    PH_OFF2_SHORT: begin
                        off_final = off_short;
                        finish    = 1'b1;
                    end
                    PH_OFF2_LONG: begin
                        offset_next = off_short;
                        phase_next  = PH_OFF3;
                    end
                    PH_OFF3: begin
                        off_final = off_long;
                        finish    = 1'b1;
                    end
                    PH_COPY: begin
                        // A compressed byte while a copy is pending is reported and dropped.
                        q_push       = 1'b1;
                        q_cmd.kind   = CMD_STATUS;
                        q_cmd.status = ST_FEED_BUSY;
                    end
                    default: begin
                        phase_next = PH_TOKEN;
                    end
                endcase
            end

            if (finish) begin
                offset_next = off_final;
                if (off_bad) begin
                    q_push        = 1'b1;
                    q_cmd.kind    = CMD_STATUS;
                    q_cmd.status  = ST_BAD_OFFSET;
                    run_left_next = '0;
                    phase_next    = PH_TOKEN;
                end else begin
                    phase_next = PH_COPY;
                end
            end

            if (q_push && q_cmd.kind != CMD_STATUS) begin
                wr_pos_next = wr_pos_reg + HIST_AW'(1);
                if (filled_reg != FILL_W'(WINDOW_BYTES)) begin
                    filled_next = filled_reg + FILL_W'(1);
                end
            end
        end
    end

    assign off_bad = (off_final == '0)
                  || (off_final > {{(OFFSET_W-FILL_W){1'b0}}, filled_reg})
                  || (off_final > OFFSET_W'(WINDOW_BYTES));

endmodule

// ----- design/lzbsd_cmd_fifo.sv -----
// Short command queue that decouples the parser from the history executor.
`timescale 1ns / 1ps

module lzbsd_cmd_fifo import lzbsd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  cmd_t  push_cmd,
    input  logic  pop,
    output cmd_t  head_cmd,
    output logic  full,
    output logic  empty
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_AW:0]      count_reg;
    logic                  do_push, do_pop;

    assign full     = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (CMDQ_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (CMDQ_AW+1)'(1);
            end
        end
    end

endmodule

// ----- design/lzbsd_back.sv -----
// History executor: reads and writes the window memory and drives the result stream.
`timescale 1ns / 1ps

module lzbsd_back import lzbsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        head_cmd,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic [7:0]   hist_mem [WINDOW_BYTES];
    logic [7:0]   rd_q_reg;

    logic         s1_valid_reg;
    cmd_t         s1_cmd_reg;
    logic         fwd_hit_reg;
    logic [7:0]   fwd_byte_reg;

    logic         m_valid_reg;
    logic [7:0]   m_data_reg;
    logic [1:0]   m_status_reg;
    logic         m_last_reg;

    logic         advance;
    logic [7:0]   s1_byte;
    logic         s1_writes;

    assign advance   = !m_valid_reg || m_tready;
    assign q_pop     = advance && !q_empty;
    assign s1_writes = s1_valid_reg && (s1_cmd_reg.kind != CMD_STATUS);

    // The byte written in the cycle a copy issued its read is not yet in the
    // memory, so a copy one byte back takes it from the forwarding register.
    always_comb begin
        case (s1_cmd_reg.kind)
            CMD_LIT:  s1_byte = s1_cmd_reg.data;
            CMD_COPY: s1_byte = fwd_hit_reg ? fwd_byte_reg : rd_q_reg;
            default:  s1_byte = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_writes) begin
            hist_mem[s1_cmd_reg.wr_addr] <= s1_byte;
        end
        if (q_pop) begin
            rd_q_reg <= hist_mem[head_cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cmd_reg   <= head_cmd;
            fwd_hit_reg  <= s1_writes && (s1_cmd_reg.wr_addr == head_cmd.rd_addr);
            fwd_byte_reg <= s1_byte;
            if (s1_valid_reg) begin
                m_data_reg   <= s1_byte;
                m_status_reg <= s1_cmd_reg.status;
                m_last_reg   <= s1_cmd_reg.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= q_pop;
            m_valid_reg  <= s1_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- design/lz_byte_stream_decompressor_unit.sv -----
// Top level of the byte-oriented LZ77 stream decompressor.
`timescale 1ns / 1ps

// The block takes one beat per clock cycle on the input stream while the
// command queue is not full, and gives at most one result beat for it; the
// beat's command passes through the queue, the executor stage register and the
// output register. A beat with tuser low feeds one compressed byte: tokens, length
// and offset bytes are absorbed without data, while literal bytes come straight
// back as data. A beat with tuser high pulls one byte of a pending match copy
// from the history window; a pull with no copy pending is dropped without a
// result. Result tuser is 0 for a data byte, 1 when a match with an offset of
// zero or beyond the bytes written so far is dropped, and 2 when a compressed
// byte arrives while a copy is pending (that byte is ignored). tlast marks the
// final byte of a literal run or of a match copy. The sustained rate of one
// beat per cycle, when neither side stalls, is set by the simple dual-port history
// memory, which takes one read and one write per cycle; a small forwarding register
// covers copies that reach back one byte. A four-entry command queue sits between
// the parser and the history executor, so input beats keep flowing while a result
// waits on the output. The history memory needs no clearing after reset: a match
// can only reach bytes that have already been written.

module lz_byte_stream_decompressor_unit import lzbsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] action (0 feed, 1 pull)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    // Commands travel from the parser to the executor through the queue.
    cmd_t  push_cmd;
    cmd_t  head_cmd;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    lzbsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    lzbsd_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    lzbsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
